// ===== src/su8vc_pkg.sv =====
// ----------------------------------------------------------------------------
// su8vc_pkg
// Shared types and constants of the strict UTF-8 validator and counter.
// ----------------------------------------------------------------------------
package su8vc_pkg;

   // Range allowed for the next continuation byte.
   typedef enum logic [2:0] {
      RULE_ANY = 3'd0,  // 80..BF
      RULE_E0  = 3'd1,  // A0..BF, rules out overlong three-byte forms
      RULE_ED  = 3'd2,  // 80..9F, rules out surrogates
      RULE_F0  = 3'd3,  // 90..BF, rules out overlong four-byte forms
      RULE_F4  = 3'd4   // 80..8F, rules out code points above U+10FFFF
   } rule_type;

   localparam logic [7:0] LEAD2_LO  = 8'hC2;
   localparam logic [7:0] LEAD2_HI  = 8'hDF;
   localparam logic [7:0] LEAD_E0   = 8'hE0;
   localparam logic [7:0] LEAD_ED   = 8'hED;
   localparam logic [7:0] LEAD3_HI  = 8'hEF;
   localparam logic [7:0] LEAD_F0   = 8'hF0;
   localparam logic [7:0] LEAD_F4   = 8'hF4;
   localparam logic [7:0] ASCII_HI  = 8'h7F;
   localparam logic [7:0] CONT_LO   = 8'h80;
   localparam logic [7:0] CONT_8F   = 8'h8F;
   localparam logic [7:0] CONT_90   = 8'h90;
   localparam logic [7:0] CONT_9F   = 8'h9F;
   localparam logic [7:0] CONT_A0   = 8'hA0;
   localparam logic [7:0] CONT_HI   = 8'hBF;
   localparam logic [7:0] CONT_MASK = 8'hC0;
   localparam logic [7:0] NUL_BYTE  = 8'h00;

   localparam int unsigned OUT_COUNT_WIDTH = 16;

   // Decoder state carried from byte to byte.
   typedef struct packed {
      logic [1:0] pend;     // continuation bytes still expected
      rule_type   rule;     // range for the next continuation byte
      logic       err;      // an encoding rule was broken
      logic       nul;      // a zero byte was seen
   } step_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic                       text_ok;
      logic                       bad_encoding;
      logic                       nul_found;
      logic [OUT_COUNT_WIDTH-1:0] code_points;
      logic                       count_clipped;
   } rsp_type;

endpackage

// ===== src/su8vc_req_if.sv =====
// ----------------------------------------------------------------------------
// su8vc_req_if
// Valid/ready channel carrying one string byte per transaction.
// ----------------------------------------------------------------------------
interface su8vc_req_if;
   logic                 valid;
   logic                 ready;
   su8vc_pkg::req_type   payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/su8vc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// su8vc_rsp_if
// Valid/ready channel carrying one per-string summary per transaction.
// ----------------------------------------------------------------------------
interface su8vc_rsp_if;
   logic                 valid;
   logic                 ready;
   su8vc_pkg::rsp_type   payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/su8vc_step.sv =====
// ----------------------------------------------------------------------------
// su8vc_step
// Combinational UTF-8 decoder step: one byte against the current state.
// ----------------------------------------------------------------------------
module su8vc_step (
   input  logic [7:0]                data_byte,
   input  su8vc_pkg::step_state_type cur,
   output su8vc_pkg::step_state_type nxt,
   output logic                      bump
);

   logic cont_ok;

   // Is the byte a continuation byte in the range the open sequence allows?
   always_comb begin
      unique case (cur.rule)
         su8vc_pkg::RULE_E0: cont_ok = (data_byte >= su8vc_pkg::CONT_A0) &&
                                       (data_byte <= su8vc_pkg::CONT_HI);
         su8vc_pkg::RULE_ED: cont_ok = (data_byte >= su8vc_pkg::CONT_LO) &&
                                       (data_byte <= su8vc_pkg::CONT_9F);
         su8vc_pkg::RULE_F0: cont_ok = (data_byte >= su8vc_pkg::CONT_90) &&
                                       (data_byte <= su8vc_pkg::CONT_HI);
         su8vc_pkg::RULE_F4: cont_ok = (data_byte >= su8vc_pkg::CONT_LO) &&
                                       (data_byte <= su8vc_pkg::CONT_8F);
         default:            cont_ok = (data_byte & su8vc_pkg::CONT_MASK) ==
                                       su8vc_pkg::CONT_LO;
      endcase
   end

   always_comb begin
      nxt  = cur;
      bump = 1'b0;
      if ((cur.pend != 2'd0) && cont_ok) begin
         nxt.rule = su8vc_pkg::RULE_ANY;
         nxt.pend = cur.pend - 2'd1;
         bump     = (cur.pend == 2'd1);
      end else begin
         // A broken sequence is dropped and the same byte is decoded as a lead.
         if (cur.pend != 2'd0) begin
            nxt.err = 1'b1;
         end
         nxt.pend = 2'd0;
         nxt.rule = su8vc_pkg::RULE_ANY;
         priority if (data_byte <= su8vc_pkg::ASCII_HI) begin
            bump = 1'b1;
            if (data_byte == su8vc_pkg::NUL_BYTE) begin
               nxt.nul = 1'b1;
            end
         end else if ((data_byte >= su8vc_pkg::LEAD2_LO) &&
                      (data_byte <= su8vc_pkg::LEAD2_HI)) begin
            nxt.pend = 2'd1;
         end else if (data_byte == su8vc_pkg::LEAD_E0) begin
            nxt.pend = 2'd2;
            nxt.rule = su8vc_pkg::RULE_E0;
         end else if (data_byte == su8vc_pkg::LEAD_ED) begin
            nxt.pend = 2'd2;
            nxt.rule = su8vc_pkg::RULE_ED;
         end else if ((data_byte > su8vc_pkg::LEAD_E0) &&
                      (data_byte <= su8vc_pkg::LEAD3_HI)) begin
            nxt.pend = 2'd2;
         end else if (data_byte == su8vc_pkg::LEAD_F0) begin
            nxt.pend = 2'd3;
            nxt.rule = su8vc_pkg::RULE_F0;
         end else if (data_byte == su8vc_pkg::LEAD_F4) begin
            nxt.pend = 2'd3;
            nxt.rule = su8vc_pkg::RULE_F4;
         end else if ((data_byte > su8vc_pkg::LEAD_F0) &&
                      (data_byte < su8vc_pkg::LEAD_F4)) begin
            nxt.pend = 2'd3;
         end else begin
            // Stray continuation, C0/C1 or F5..FF as a lead byte.
            nxt.err = 1'b1;
         end
      end
   end

endmodule

// ===== src/strict_utf8_validate_count.sv =====
// ----------------------------------------------------------------------------
// strict_utf8_validate_count
// Strict UTF-8 validator with NUL detection and code point counting.
// ----------------------------------------------------------------------------
// A string enters one byte per request transaction, with last_byte set on its
// final byte; a string always has at least one byte. The block accepts one
// byte every clock cycle unless the input stalls as described below. Each byte
// is first captured in an input register, then decoded by a short
// combinational step that updates the decoder state and code point counter,
// and on the final byte the summary is written into the response register,
// which drives the response channel. The response register lets the next
// string stream in while the summary waits; the input stalls only when a new
// final byte would overwrite a summary that has not been taken yet. After the
// final byte all state clears for the next string.
// ----------------------------------------------------------------------------
module strict_utf8_validate_count #(
   parameter int unsigned COUNT_WIDTH = 16  // code point counter width, 8..32
) (
   input  logic               clock,
   input  logic               reset,
   su8vc_req_if.sink          req_chan,
   su8vc_rsp_if.source        rsp_chan
);

   // Input register stage.
   logic                      stg_valid_ff, stg_valid_in;
   su8vc_pkg::req_type        stg_ff;

   // Decoder state that persists across the bytes of one string.
   su8vc_pkg::step_state_type st_ff, st_nxt;
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic                      ovf_ff, ovf_in;
   logic                      bump;

   // Response register.
   logic                      rsp_valid_ff, rsp_valid_in;
   su8vc_pkg::rsp_type        rsp_ff, rsp_in;

   logic                      step_go;
   logic                      high_count;
   logic [su8vc_pkg::OUT_COUNT_WIDTH-1:0] cp_clamped;

   // The staged byte moves on unless it is a final byte and the response
   // register still holds a summary nobody has taken.
   assign step_go = stg_valid_ff &&
                    (!stg_ff.last_byte || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !stg_valid_ff || step_go;

   assign stg_valid_in = req_chan.ready ? req_chan.valid : stg_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
      if (req_chan.ready && req_chan.valid) begin
         stg_ff <= req_chan.payload;
      end
   end

   su8vc_step u_step (
      .data_byte (stg_ff.data_byte),
      .cur       (st_ff),
      .nxt       (st_nxt),
      .bump      (bump)
   );

   // Counter saturates at its own maximum; the overflow flag remembers that.
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (bump) begin
         if (count_ff == {COUNT_WIDTH{1'b1}}) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + COUNT_WIDTH'(1);
         end
      end
   end

   // Clamp the count to the 16-bit result field.
   generate
      if (COUNT_WIDTH > su8vc_pkg::OUT_COUNT_WIDTH) begin : g_wide
         assign high_count = |count_in[COUNT_WIDTH-1:su8vc_pkg::OUT_COUNT_WIDTH];
         assign cp_clamped = high_count ? {su8vc_pkg::OUT_COUNT_WIDTH{1'b1}}
                                        : count_in[su8vc_pkg::OUT_COUNT_WIDTH-1:0];
      end else begin : g_narrow
         assign high_count = 1'b0;
         assign cp_clamped = su8vc_pkg::OUT_COUNT_WIDTH'(count_in);
      end
   endgenerate

   // Summary of the string as it stands after the staged byte.
   always_comb begin
      rsp_in.bad_encoding  = st_nxt.err || (st_nxt.pend != 2'd0);
      rsp_in.nul_found     = st_nxt.nul;
      rsp_in.text_ok       = !rsp_in.bad_encoding && !st_nxt.nul;
      rsp_in.code_points   = cp_clamped;
      rsp_in.count_clipped = ovf_in || high_count;
   end

   assign rsp_valid_in = (step_go && stg_ff.last_byte) ||
                         (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step_go) begin
            // A final byte returns the decoder to its cleared state.
            if (stg_ff.last_byte) begin
               st_ff    <= '0;
               count_ff <= '0;
               ovf_ff   <= 1'b0;
            end else begin
               st_ff    <= st_nxt;
               count_ff <= count_in;
               ovf_ff   <= ovf_in;
            end
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (step_go && stg_ff.last_byte) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // A narrowed continuation range only exists while a sequence is open.
   a_rule_needs_pend : assert property (@(posedge clock) disable iff (reset)
      (st_ff.rule != su8vc_pkg::RULE_ANY) |-> (st_ff.pend != 2'd0))
      else $error("continuation rule set with no open sequence");

   // A new response only follows a final byte leaving the input stage.
   a_rsp_from_last : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_go && stg_ff.last_byte))
      else $error("response raised without a final byte");

   // The summary flags stay consistent with each other.
   a_ok_consistent : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.text_ok ==
                        (!rsp_ff.bad_encoding && !rsp_ff.nul_found)))
      else $error("text_ok disagrees with error flags");

endmodule
